### hdl/ffpa_pkg.sv
// Shared types and codes of the first-fit partition allocator.
package ffpa_pkg;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WR_REST,
    S_WR_HIT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NO_HOLE   = 3'd2,
    ST_DUP       = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [15:0] SEGMENT_SIZE_RESET = 16'd4096;

  typedef struct packed {
    logic        free;
    logic [7:0]  owner;
    logic [15:0] size;
    logic [15:0] start;
  } entry_t;

endpackage

### hdl/ffpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/first_fit_partition_allocator.sv
// Top level of the first-fit partition allocator: sequencer, scan datapath, table RAM.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: req_type (0 store,
//   1 remove), part_id and req_size. Output channel (out_valid/out_ready)
//   returns one item per request: status and start_offset.
//   Config channel (cfg_valid/cfg_ready) writes segment_size; the write
//   reinitializes the table to one free partition over the whole segment.
//   Timing: a request reads the table entries 0..entry_count-1 through the
//   single RAM read port, one entry per cycle. After the scan come a decide
//   step, a write of the remainder on a split, a write of the entry when one is
//   rewritten, and the done step that loads the result. in_ready is high only
//   while the sequencer is idle, from the cycle after the result is loaded, so
//   one request is at work at a time. The result sits in an output register;
//   the next request may be accepted while it waits. If the receiver stalls,
//   a finished request holds in its last step until the output register
//   frees.
//   Reset: segment_size returns to 4096 and the init step rewrites entry 0;
//   ready signals are low during that step. A config write passes through the same step.
module first_fit_partition_allocator #(
  parameter int MAX_PARTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] segment_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  part_id,
  input  logic [15:0] req_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] start_offset
);

  localparam int AW = $clog2(MAX_PARTS);
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int EW = $bits(ffpa_pkg::entry_t);

  ffpa_pkg::state_t state, state_next;

  logic [15:0] seg_size;
  logic [CW-1:0] entry_count;

  logic        req_type_r;
  logic [7:0]  part_id_r;
  logic [15:0] req_size_r;

  logic [CW-1:0] issue_idx;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;

  logic          match_found;
  logic [AW-1:0] match_idx;
  logic [15:0]   match_size;
  logic [15:0]   match_start;
  logic          fit_found;
  logic [AW-1:0] fit_idx;
  logic [15:0]   fit_size;
  logic [15:0]   fit_start;

  logic [2:0]        res_status;
  logic [15:0]       res_start;
  logic [AW-1:0]     hit_idx;
  ffpa_pkg::entry_t  hit_entry;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  ffpa_pkg::entry_t  ram_wdata;
  logic [EW-1:0]     ram_rdata;
  ffpa_pkg::entry_t  rd_entry;

  logic issuing;
  logic out_free;
  logic too_large;
  logic cfg_fire, in_fire;

  assign rd_entry  = ffpa_pkg::entry_t'(ram_rdata);
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = (state == ffpa_pkg::S_IDLE);
  assign in_ready  = (state == ffpa_pkg::S_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign issuing   = (state == ffpa_pkg::S_SCAN) && (issue_idx != entry_count);
  assign too_large = (req_size_r == 16'd0) || (req_size_r > seg_size);

  ffpa_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PARTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(issue_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffpa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    unique case (state)
      ffpa_pkg::S_INIT: begin
        ram_we          = 1'b1;
        ram_wdata.free  = 1'b1;
        ram_wdata.size  = seg_size;
        state_next      = ffpa_pkg::S_IDLE;
      end
      ffpa_pkg::S_IDLE: begin
        if (cfg_fire) begin
          state_next = ffpa_pkg::S_INIT;
        end else if (in_fire) begin
          state_next = ffpa_pkg::S_SCAN;
        end
      end
      ffpa_pkg::S_SCAN: begin
        if (!issuing && !rd_valid) begin
          state_next = ffpa_pkg::S_DECIDE;
        end
      end
      ffpa_pkg::S_DECIDE: begin
        if (req_type_r == ffpa_pkg::REQ_REMOVE) begin
          state_next = match_found ? ffpa_pkg::S_WR_HIT : ffpa_pkg::S_DONE;
        end else if (match_found || too_large || !fit_found) begin
          state_next = ffpa_pkg::S_DONE;
        end else if (fit_size > req_size_r) begin
          state_next = (entry_count == CW'(MAX_PARTS)) ? ffpa_pkg::S_DONE
                                                       : ffpa_pkg::S_WR_REST;
        end else begin
          state_next = ffpa_pkg::S_WR_HIT;
        end
      end
      ffpa_pkg::S_WR_REST: begin
        // free remainder goes to the end of the table
        ram_we          = 1'b1;
        ram_waddr       = entry_count[AW-1:0];
        ram_wdata.free  = 1'b1;
        ram_wdata.size  = fit_size - req_size_r;
        ram_wdata.start = fit_start + req_size_r;
        state_next      = ffpa_pkg::S_WR_HIT;
      end
      ffpa_pkg::S_WR_HIT: begin
        ram_we     = 1'b1;
        ram_waddr  = hit_idx;
        ram_wdata  = hit_entry;
        state_next = ffpa_pkg::S_DONE;
      end
      ffpa_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ffpa_pkg::S_IDLE;
        end
      end
      default: state_next = ffpa_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size    <= ffpa_pkg::SEGMENT_SIZE_RESET;
      entry_count <= CW'(1);
      out_valid   <= 1'b0;
      rd_valid    <= 1'b0;
      issue_idx   <= '0;
      match_found <= 1'b0;
      fit_found   <= 1'b0;
    end else begin
      rd_valid <= issuing;
      if (issuing) begin
        issue_idx <= issue_idx + CW'(1);
      end
      if (cfg_fire) begin
        seg_size <= segment_size;
      end
      if (state == ffpa_pkg::S_INIT) begin
        entry_count <= CW'(1);
      end
      if (state == ffpa_pkg::S_WR_REST) begin
        entry_count <= entry_count + CW'(1);
      end
      if (in_fire) begin
        issue_idx   <= '0;
        match_found <= 1'b0;
        fit_found   <= 1'b0;
      end
      if (rd_valid) begin
        if (!rd_entry.free && rd_entry.owner == part_id_r && !match_found) begin
          match_found <= 1'b1;
        end
        if (rd_entry.free && rd_entry.size >= req_size_r && !fit_found) begin
          fit_found <= 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ffpa_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= issue_idx[AW-1:0];
    if (in_fire) begin
      req_type_r <= req_type;
      part_id_r  <= part_id;
      req_size_r <= req_size;
    end
    if (rd_valid) begin
      if (!rd_entry.free && rd_entry.owner == part_id_r && !match_found) begin
        match_idx   <= rd_idx;
        match_size  <= rd_entry.size;
        match_start <= rd_entry.start;
      end
      if (rd_entry.free && rd_entry.size >= req_size_r && !fit_found) begin
        fit_idx   <= rd_idx;
        fit_size  <= rd_entry.size;
        fit_start <= rd_entry.start;
      end
    end
    if (state == ffpa_pkg::S_DECIDE) begin
      res_start <= 16'd0;
      if (req_type_r == ffpa_pkg::REQ_REMOVE) begin
        // a freed entry keeps its size
        hit_idx         <= match_idx;
        hit_entry.free  <= 1'b1;
        hit_entry.owner <= 8'd0;
        hit_entry.size  <= match_size;
        hit_entry.start <= match_start;
        if (match_found) begin
          res_status <= ffpa_pkg::ST_REMOVED;
          res_start  <= match_start;
        end else begin
          res_status <= ffpa_pkg::ST_UNKNOWN;
        end
      end else begin
        hit_idx         <= fit_idx;
        hit_entry.free  <= 1'b0;
        hit_entry.owner <= part_id_r;
        hit_entry.size  <= req_size_r;
        hit_entry.start <= fit_start;
        if (match_found) begin
          res_status <= ffpa_pkg::ST_DUP;
        end else if (too_large) begin
          res_status <= ffpa_pkg::ST_TOO_LARGE;
        end else if (!fit_found) begin
          res_status <= ffpa_pkg::ST_NO_HOLE;
        end else if (fit_size > req_size_r && entry_count == CW'(MAX_PARTS)) begin
          res_status <= ffpa_pkg::ST_FULL;
        end else begin
          res_status <= ffpa_pkg::ST_STORED;
          res_start  <= fit_start;
        end
      end
    end
    if (state == ffpa_pkg::S_DONE && out_free) begin
      status       <= res_status;
      start_offset <= res_start;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count != '0 && entry_count <= CW'(MAX_PARTS))
    else $error("entry_count out of range");

  a_count_grows_on_split: assert property (@(posedge clk) disable iff (rst)
    (state != ffpa_pkg::S_WR_REST && state != ffpa_pkg::S_INIT) |=> $stable(entry_count))
    else $error("entry_count changed outside a split or init");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ffpa_pkg::S_DONE)
    else $error("result loaded outside the done step");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ffpa_pkg::S_SCAN)
    else $error("accepted request did not start a scan");
`endif

endmodule

### tb/first_fit_partition_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench for the first-fit partition allocator: queued stimulus, table predictor, checker.
module first_fit_partition_allocator_tb;

  localparam int PART_SLOTS = 64;
  localparam int REQ_TARGET = 1550;
  localparam int SETTLE = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL = 80;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic        rtype;
    logic [7:0]  id;
    logic [15:0] bytes;
    int unsigned gap;
  } step_t;

  typedef struct {
    ffpa_pkg::status_t st;
    logic [15:0]       offs;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] segment_size = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  part_id = '0;
  logic [15:0] req_size = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] start_offset;

  first_fit_partition_allocator #(.MAX_PARTS(PART_SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .segment_size (segment_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .part_id      (part_id),
    .req_size     (req_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .start_offset (start_offset)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------- predictor: mirror of the partition table ----------------
  ffpa_pkg::entry_t part_map [PART_SLOTS];
  int unsigned      part_cnt;
  logic [15:0]      seg_bytes;

  function automatic void table_clear(input logic [15:0] total);
    seg_bytes = total;
    foreach (part_map[i]) part_map[i] = '0;
    part_map[0].free = 1'b1;
    part_map[0].size = total;
    part_cnt = 1;
  endfunction

  function automatic int find_owner(input logic [7:0] id);
    for (int i = 0; i < int'(part_cnt); i++)
      if (!part_map[i].free && part_map[i].owner == id) return i;
    return -1;
  endfunction

  function automatic void apply_request(input logic rtype, input logic [7:0] id,
                                        input logic [15:0] bytes,
                                        output ffpa_pkg::status_t st,
                                        output logic [15:0] offs);
    int idx;
    int hit;
    st = ffpa_pkg::ST_STORED;
    offs = '0;
    hit = -1;
    idx = find_owner(id);
    if (rtype == ffpa_pkg::REQ_REMOVE) begin
      if (idx < 0) begin
        st = ffpa_pkg::ST_UNKNOWN;
      end else begin
        part_map[idx].free = 1'b1;
        part_map[idx].owner = '0;
        st = ffpa_pkg::ST_REMOVED;
        offs = part_map[idx].start;
      end
      return;
    end
    if (idx >= 0) begin
      st = ffpa_pkg::ST_DUP;
      return;
    end
    if (bytes == 0 || bytes > seg_bytes) begin
      st = ffpa_pkg::ST_TOO_LARGE;
      return;
    end
    for (int i = 0; i < int'(part_cnt); i++)
      if (part_map[i].free && part_map[i].size >= bytes) begin
        hit = i;
        break;
      end
    if (hit < 0) begin
      st = ffpa_pkg::ST_NO_HOLE;
      return;
    end
    if (part_map[hit].size > bytes) begin
      // split needs a spare slot for the remainder
      if (part_cnt >= PART_SLOTS) begin
        st = ffpa_pkg::ST_FULL;
        return;
      end
      part_map[part_cnt].free  = 1'b1;
      part_map[part_cnt].owner = '0;
      part_map[part_cnt].size  = part_map[hit].size - bytes;
      part_map[part_cnt].start = part_map[hit].start + bytes;
      part_cnt++;
      part_map[hit].size = bytes;
    end
    part_map[hit].free = 1'b0;
    part_map[hit].owner = id;
    offs = part_map[hit].start;
  endfunction

  // ---------------- stimulus queue ----------------
  step_t       step_q [$];
  logic        tx_eager = 1'b0;
  int unsigned req_n = 0;

  function automatic int unsigned draw_gap();
    return tx_eager ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void push_req(input logic rtype, input logic [7:0] id,
                                   input logic [15:0] bytes);
    step_q.push_back('{OP_REQ, rtype, id, bytes, draw_gap()});
    req_n++;
  endfunction

  function automatic void push_cfg(input logic [15:0] total);
    step_q.push_back('{OP_CFG, 1'b0, 8'd0, total, draw_gap()});
  endfunction

  function automatic void push_drain();
    step_q.push_back('{OP_DRAIN, 1'b0, 8'd0, 16'd0, 0});
  endfunction

  // ---------------- driver ----------------
  int unsigned gap_left;
  logic        gap_armed;
  int unsigned busy_n = 0;
  int unsigned quiet_n = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_armed = 1'b0;
      gap_left = 0;
    end else if (in_valid || cfg_valid) begin
      if (in_valid && in_ready) in_valid <= 1'b0;
      if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
    end else if (step_q.size() > 0) begin
      if (!gap_armed) begin
        gap_left = step_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        case (step_q[0].kind)
          OP_REQ: begin
            req_type <= step_q[0].rtype;
            part_id <= step_q[0].id;
            req_size <= step_q[0].bytes;
            in_valid <= 1'b1;
            void'(step_q.pop_front());
            gap_armed = 1'b0;
          end
          OP_CFG: begin
            // table rewrite only with nothing in flight
            if (busy_n == 0 && quiet_n >= SETTLE) begin
              segment_size <= step_q[0].bytes;
              cfg_valid <= 1'b1;
              void'(step_q.pop_front());
              gap_armed = 1'b0;
            end
          end
          default: begin
            if (busy_n == 0) begin
              void'(step_q.pop_front());
              gap_armed = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // ---------------- monitor / checker ----------------
  reply_t      due_replies [$];
  int unsigned stall_left;
  int unsigned idle_cycles = 0;
  int unsigned fail_n = 0;
  int unsigned reply_n = 0;
  logic        rx_eager = 1'b0;

  always @(posedge clk) begin : mon
    reply_t             want;
    ffpa_pkg::status_t  st;
    logic [15:0]        offs;
    logic               took;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 19);
      table_clear(ffpa_pkg::SEGMENT_SIZE_RESET);
      due_replies.delete();
      busy_n <= 0;
      quiet_n <= 0;
      idle_cycles = 0;
    end else begin
      took = 1'b0;
      if (out_valid && out_ready) begin
        took = 1'b1;
        if (due_replies.size() == 0) begin
          fail_n++;
          $display("%0t: unexpected item: status %0d offset %0d",
                   $time, status, start_offset);
        end else begin
          want = due_replies.pop_front();
          if (status !== want.st) begin
            fail_n++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.st, status);
          end
          if (start_offset !== want.offs) begin
            fail_n++;
            $display("%0t: start_offset mismatch: expected %0d actual %0d",
                     $time, want.offs, start_offset);
          end
        end
        reply_n++;
        if (reply_n % 100 == 0) rx_eager = ($urandom_range(0, 3) == 0);
        stall_left = rx_eager ? 0 : $urandom_range(0, 19);
      end else if (stall_left > 0 && out_valid) begin
        stall_left--;
      end
      if (cfg_valid && cfg_ready) begin
        took = 1'b1;
        table_clear(segment_size);
      end
      if (in_valid && in_ready) begin
        took = 1'b1;
        apply_request(req_type, part_id, req_size, st, offs);
        due_replies.push_back('{st, offs});
      end
      out_ready <= (stall_left == 0);
      busy_n <= due_replies.size();
      quiet_n <= took ? 0 : quiet_n + 1;
      idle_cycles = took ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------- stimulus build and end of run ----------------
  initial begin
    logic [15:0] seg;
    logic [15:0] max_sz;
    logic [7:0]  id;
    int          live_id [$];
    int          live_sz [$];
    int          freed_sz [$];
    int          n;
    int          k;
    int          r;
    int          phase;
    logic        fill;

    // reset segment is 4096
    push_req(ffpa_pkg::REQ_STORE, 8'd7, 16'd0);
    push_req(ffpa_pkg::REQ_STORE, 8'd7, 16'd4097);
    push_req(ffpa_pkg::REQ_STORE, 8'd7, 16'hFFFF);
    push_req(ffpa_pkg::REQ_STORE, 8'd0, 16'd1000);
    push_req(ffpa_pkg::REQ_STORE, 8'd0, 16'd10);
    push_req(ffpa_pkg::REQ_STORE, 8'd255, 16'd3096);
    push_req(ffpa_pkg::REQ_STORE, 8'd9, 16'd1);
    push_req(ffpa_pkg::REQ_REMOVE, 8'd200, 16'hFFFF);
    push_req(ffpa_pkg::REQ_REMOVE, 8'd0, 16'd0);
    push_req(ffpa_pkg::REQ_REMOVE, 8'd0, 16'd0);
    push_req(ffpa_pkg::REQ_STORE, 8'd0, 16'd2000);
    push_req(ffpa_pkg::REQ_STORE, 8'd3, 16'd1000);
    push_drain();
    // zero-size segment rejects everything
    push_cfg(16'd0);
    push_req(ffpa_pkg::REQ_STORE, 8'd1, 16'd1);
    push_req(ffpa_pkg::REQ_REMOVE, 8'd3, 16'd0);
    push_cfg(16'hFFFF);
    push_req(ffpa_pkg::REQ_STORE, 8'd128, 16'hFFFF);
    push_req(ffpa_pkg::REQ_STORE, 8'd129, 16'd1);
    push_req(ffpa_pkg::REQ_REMOVE, 8'd128, 16'd0);
    push_cfg(16'd1);
    push_req(ffpa_pkg::REQ_STORE, 8'd2, 16'd1);
    push_req(ffpa_pkg::REQ_STORE, 8'd4, 16'd1);
    push_req(ffpa_pkg::REQ_REMOVE, 8'd2, 16'd1);

    phase = 0;
    while (req_n < REQ_TARGET) begin
      fill = (phase == 0) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: seg = 16'hFFFF;
        1: seg = 16'($urandom_range(1, 8));
        2: seg = 16'($urandom_range(9, 300));
        3: seg = 16'($urandom_range(300, 5000));
        default: seg = 16'($urandom_range(1, 65535));
      endcase
      if (phase == 0) seg = 16'hFFFF;
      tx_eager = (phase != 0) && ($urandom_range(0, 3) == 0);
      push_cfg(seg);
      live_id.delete();
      live_sz.delete();
      freed_sz.delete();
      n = $urandom_range(60, 180);
      for (k = 0; k < n && req_n < REQ_TARGET; k++) begin
        if (k == n / 2 && $urandom_range(0, 3) == 0) push_drain();
        max_sz = seg >> (fill ? $urandom_range(7, 10) : $urandom_range(1, 7));
        if (max_sz == 0) max_sz = 1;
        r = $urandom_range(0, 99);
        if (fill && r < 80) r = 0;
        if (r < 50) begin
          id = 8'($urandom_range(0, 255));
          live_id.push_back(int'(id));
          live_sz.push_back(int'($urandom_range(1, max_sz)));
          push_req(ffpa_pkg::REQ_STORE, id, 16'(live_sz[$]));
          if (live_id.size() > 80) begin
            void'(live_id.pop_front());
            void'(live_sz.pop_front());
          end
        end else if (r < 65 && freed_sz.size() > 0) begin
          // same size as a freed hole: exact-fit path
          id = 8'($urandom_range(0, 255));
          r = $urandom_range(0, freed_sz.size() - 1);
          live_id.push_back(int'(id));
          live_sz.push_back(freed_sz[r]);
          push_req(ffpa_pkg::REQ_STORE, id, 16'(freed_sz[r]));
          freed_sz.delete(r);
        end else if (r < 85 && live_id.size() > 0) begin
          r = $urandom_range(0, live_id.size() - 1);
          push_req(ffpa_pkg::REQ_REMOVE, 8'(live_id[r]), 16'($urandom_range(0, 65535)));
          freed_sz.push_back(live_sz[r]);
          live_id.delete(r);
          live_sz.delete(r);
        end else if (r < 90 && live_id.size() > 0) begin
          r = $urandom_range(0, live_id.size() - 1);
          push_req(ffpa_pkg::REQ_STORE, 8'(live_id[r]), 16'($urandom_range(1, max_sz)));
        end else if (r < 95) begin
          push_req(ffpa_pkg::REQ_REMOVE, 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)));
        end else begin
          push_req(ffpa_pkg::REQ_STORE, 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
        end
      end
      phase++;
    end

    do @(negedge clk);
    while (step_q.size() != 0 || in_valid || cfg_valid || due_replies.size() != 0);
    repeat (TAIL) @(negedge clk);
    if (fail_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
